/* hdl/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types and constants of the thermistor table interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int ResW  = 24;
  localparam int RawW  = 16;
  localparam int TempW = 14;
  localparam int PtsW  = 6;
  localparam int ProdW = ResW + RawW;
  localparam int AddrW = 4;

  localparam logic [ResW-1:0] ResMax = {ResW{1'b1}};

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] RegBottom = 2'd0;
  localparam logic [1:0] RegFull   = 2'd1;
  localparam logic [1:0] RegPoints = 2'd2;

  typedef enum logic [1:0] {
    RANGE_INTERP = 2'd0,
    RANGE_HOT    = 2'd1,
    RANGE_COLD   = 2'd2,
    RANGE_KEEP   = 2'd3
  } range_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RES, S_DIVR, S_WAITR, S_RD0, S_CHK0, S_CHKN,
    S_SCAN, S_DIVT, S_WAITT, S_FIN
  } state_e;

  typedef enum logic [1:0] { RS_MAX, RS_ZERO, RS_QUOT } res_src_e;
  typedef enum logic [1:0] { TS_RD, TS_HI, TS_LAST, TS_INTERP } temp_src_e;
  typedef enum logic [1:0] { AS_ZERO, AS_LAST, AS_ONE, AS_NEXT } addr_sel_e;

  typedef struct packed {
    logic      accept_item;
    logic      write_entry;
    logic      load_prod;
    logic      div_start;
    logic      div_interp;
    logic      load_res;
    res_src_e  res_src;
    logic      rd_en;
    addr_sel_e addr_sel;
    logic      load_hi;
    logic      idx_init;
    logic      idx_inc;
    logic      load_num;
    logic      load_temp;
    temp_src_e temp_src;
    range_e    range;
    logic      publish;
  } cmd_t;

  typedef struct packed {
    logic raw_zero;
    logic raw_over;
    logic div_done;
    logic r_ge_rd;
    logic r_le_rd;
    logic in_seg;
    logic span_zero;
    logic idx_last;
    logic out_busy;
  } sts_t;

endpackage

/* hdl/ntc_div.sv */
// ----------------------------------------------------------------------------
// ntc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_div #(
  parameter int DW = 40,
  parameter int VW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_q, rem_d, div_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   shifted, trial;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    trial   = shifted - {1'b0, div_q};
    if (shifted >= {1'b0, div_q}) begin
      rem_d = trial[VW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b1};
    end else begin
      rem_d = shifted[VW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/ntc_dp.sv */
// ----------------------------------------------------------------------------
// ntc_dp
// Datapath: calibration memory, divider resistance, segment interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_dp #(
  parameter int MAX_POINTS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ntc_pkg::cmd_t                     cmd_i,
  output ntc_pkg::sts_t                     sts_o,
  input  logic [ntc_pkg::ResW-1:0]          bottom_i,
  input  logic [ntc_pkg::RawW-1:0]          full_i,
  input  logic [ntc_pkg::PtsW-1:0]          points_i,
  input  logic [ntc_pkg::RawW-1:0]          raw_sample_i,
  input  logic [4:0]                        entry_index_i,
  input  logic [ntc_pkg::ResW-1:0]          entry_resistance_i,
  input  logic signed [ntc_pkg::TempW-1:0]  entry_temperature_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [ntc_pkg::TempW-1:0]  temperature_o,
  output logic [ntc_pkg::ResW-1:0]          measured_resistance_o,
  output logic [1:0]                        range_status_o
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int RW = ntc_pkg::ResW;
  localparam int TW = ntc_pkg::TempW;
  localparam int PW = ntc_pkg::ProdW;

  logic [RW+TW-1:0] mem [MAX_POINTS];
  logic [RW+TW-1:0] rdata_q;
  logic [IW-1:0]    rd_addr, idx_q;
  logic [7:0]       widx, pts8, n8, last8;
  logic [IW-1:0]    last_idx;

  logic [ntc_pkg::RawW-1:0] raw_q;
  logic [PW-1:0]            prod_q;
  logic [RW-1:0]            r_q, hi_res_q;
  logic signed [TW-1:0]     hi_temp_q, last_t_q, res_t_q;
  logic [1:0]               res_st_q;
  logic signed [PW-1:0]     num_q;

  logic [RW-1:0]        rd_res;
  logic signed [TW-1:0] rd_temp;

  logic                 div_done;
  logic [PW-1:0]        div_dividend, div_quot, num_mag;
  logic [RW-1:0]        div_divisor;

  logic signed [TW:0]   dt, off, t_sum;
  logic signed [RW:0]   diff;
  logic [TW-1:0]        q_lo;

  logic                       out_valid_q;
  logic signed [TW-1:0]       out_t_q;
  logic [RW-1:0]              out_r_q;
  logic [1:0]                 out_st_q;

  assign rd_res  = rdata_q[RW+TW-1:TW];
  assign rd_temp = $signed(rdata_q[TW-1:0]);

  // Clamp the number of points in use to between two and the table size.
  always_comb begin
    pts8 = {2'b0, points_i};
    if (pts8 < 8'd2) begin
      n8 = 8'd2;
    end else if (pts8 > 8'(MAX_POINTS)) begin
      n8 = 8'(MAX_POINTS);
    end else begin
      n8 = pts8;
    end
    last8    = n8 - 8'd1;
    last_idx = last8[IW-1:0];
    widx     = {3'b0, entry_index_i};
  end

  always_comb begin
    case (cmd_i.addr_sel)
      ntc_pkg::AS_ZERO: rd_addr = '0;
      ntc_pkg::AS_LAST: rd_addr = last_idx;
      ntc_pkg::AS_ONE:  rd_addr = IW'(1);
      default:          rd_addr = idx_q + 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry && (widx < 8'(MAX_POINTS))) begin
      mem[widx[IW-1:0]] <= {entry_resistance_i, entry_temperature_i};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Shared divider: resistance ratio first, then the interpolation offset.
  assign num_mag = num_q[PW-1] ? PW'(-num_q) : PW'(num_q);

  always_comb begin
    if (cmd_i.div_interp) begin
      div_dividend = num_mag;
      div_divisor  = hi_res_q - rd_res;
    end else begin
      div_dividend = prod_q;
      div_divisor  = {{(RW-ntc_pkg::RawW){1'b0}}, raw_q};
    end
  end

  ntc_div #(.DW(PW), .VW(RW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    dt    = (TW+1)'(rd_temp) - (TW+1)'(hi_temp_q);
    diff  = $signed({1'b0, hi_res_q - r_q});
    q_lo  = div_quot[TW-1:0];
    off   = num_q[PW-1] ? -$signed({1'b0, q_lo}) : $signed({1'b0, q_lo});
    t_sum = (TW+1)'(hi_temp_q) + off;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_item) begin
      raw_q <= raw_sample_i;
    end
    if (cmd_i.load_prod) begin
      prod_q <= PW'(bottom_i) * PW'(full_i - raw_q);
    end
    if (cmd_i.load_res) begin
      case (cmd_i.res_src)
        ntc_pkg::RS_MAX:  r_q <= ntc_pkg::ResMax;
        ntc_pkg::RS_ZERO: r_q <= '0;
        default:          r_q <= (|div_quot[PW-1:RW]) ? ntc_pkg::ResMax : div_quot[RW-1:0];
      endcase
    end
    if (cmd_i.load_hi) begin
      hi_res_q  <= rd_res;
      hi_temp_q <= rd_temp;
    end
    if (cmd_i.idx_init) begin
      idx_q <= IW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.load_num) begin
      num_q <= PW'(dt) * PW'(diff);
    end
    if (cmd_i.load_temp) begin
      res_st_q <= cmd_i.range;
      case (cmd_i.temp_src)
        ntc_pkg::TS_RD:   res_t_q <= rd_temp;
        ntc_pkg::TS_HI:   res_t_q <= hi_temp_q;
        ntc_pkg::TS_LAST: res_t_q <= last_t_q;
        default:          res_t_q <= t_sum[TW-1:0];
      endcase
    end
    if (cmd_i.publish) begin
      out_t_q  <= res_t_q;
      out_r_q  <= r_q;
      out_st_q <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_t_q    <= '0;
    end else begin
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
        last_t_q    <= res_t_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.raw_zero  = (raw_q == '0);
    sts_o.raw_over  = (raw_q > full_i);
    sts_o.div_done  = div_done;
    sts_o.r_ge_rd   = (r_q >= rd_res);
    sts_o.r_le_rd   = (r_q <= rd_res);
    sts_o.in_seg    = (r_q <= hi_res_q) && (r_q >= rd_res);
    sts_o.span_zero = (hi_res_q == rd_res);
    sts_o.idx_last  = (idx_q == last_idx);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o           = out_valid_q;
  assign temperature_o         = out_t_q;
  assign measured_resistance_o = out_r_q;
  assign range_status_o        = out_st_q;

endmodule

/* hdl/ntc_ctrl.sv */
// ----------------------------------------------------------------------------
// ntc_ctrl
// Controller state machine sequencing one conversion through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          action_i,
  output logic          in_ready_o,
  input  ntc_pkg::sts_t sts_i,
  output ntc_pkg::cmd_t cmd_o
);

  ntc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ntc_pkg::S_IDLE: begin
        if (in_valid_i && !action_i) state_d = ntc_pkg::S_RES;
      end
      ntc_pkg::S_RES: begin
        if (sts_i.raw_zero || sts_i.raw_over) state_d = ntc_pkg::S_RD0;
        else state_d = ntc_pkg::S_DIVR;
      end
      ntc_pkg::S_DIVR:  state_d = ntc_pkg::S_WAITR;
      ntc_pkg::S_WAITR: begin
        if (sts_i.div_done) state_d = ntc_pkg::S_RD0;
      end
      ntc_pkg::S_RD0:   state_d = ntc_pkg::S_CHK0;
      ntc_pkg::S_CHK0: begin
        state_d = sts_i.r_ge_rd ? ntc_pkg::S_FIN : ntc_pkg::S_CHKN;
      end
      ntc_pkg::S_CHKN: begin
        state_d = sts_i.r_le_rd ? ntc_pkg::S_FIN : ntc_pkg::S_SCAN;
      end
      ntc_pkg::S_SCAN: begin
        if (sts_i.in_seg) begin
          state_d = sts_i.span_zero ? ntc_pkg::S_FIN : ntc_pkg::S_DIVT;
        end else if (sts_i.idx_last) begin
          state_d = ntc_pkg::S_FIN;
        end
      end
      ntc_pkg::S_DIVT:  state_d = ntc_pkg::S_WAITT;
      ntc_pkg::S_WAITT: begin
        if (sts_i.div_done) state_d = ntc_pkg::S_FIN;
      end
      ntc_pkg::S_FIN: begin
        if (!sts_i.out_busy) state_d = ntc_pkg::S_IDLE;
      end
      default: state_d = ntc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_src  = ntc_pkg::RS_QUOT;
    cmd_o.addr_sel = ntc_pkg::AS_ZERO;
    cmd_o.temp_src = ntc_pkg::TS_RD;
    cmd_o.range    = ntc_pkg::RANGE_INTERP;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ntc_pkg::S_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.write_entry = in_valid_i && action_i;
        cmd_o.accept_item = in_valid_i && !action_i;
      end
      ntc_pkg::S_RES: begin
        if (sts_i.raw_zero) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_src  = ntc_pkg::RS_MAX;
        end else if (sts_i.raw_over) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_src  = ntc_pkg::RS_ZERO;
        end else begin
          cmd_o.load_prod = 1'b1;
        end
      end
      ntc_pkg::S_DIVR: cmd_o.div_start = 1'b1;
      ntc_pkg::S_WAITR: begin
        cmd_o.load_res = sts_i.div_done;
      end
      ntc_pkg::S_RD0: cmd_o.rd_en = 1'b1;
      ntc_pkg::S_CHK0: begin
        cmd_o.load_hi = 1'b1;
        if (sts_i.r_ge_rd) begin
          cmd_o.load_temp = 1'b1;
          cmd_o.range     = ntc_pkg::RANGE_COLD;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ntc_pkg::AS_LAST;
        end
      end
      ntc_pkg::S_CHKN: begin
        if (sts_i.r_le_rd) begin
          cmd_o.load_temp = 1'b1;
          cmd_o.range     = ntc_pkg::RANGE_HOT;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ntc_pkg::AS_ONE;
          cmd_o.idx_init = 1'b1;
        end
      end
      ntc_pkg::S_SCAN: begin
        if (sts_i.in_seg) begin
          if (sts_i.span_zero) begin
            cmd_o.load_temp = 1'b1;
            cmd_o.temp_src  = ntc_pkg::TS_HI;
          end else begin
            cmd_o.load_num = 1'b1;
          end
        end else if (sts_i.idx_last) begin
          cmd_o.load_temp = 1'b1;
          cmd_o.temp_src  = ntc_pkg::TS_LAST;
          cmd_o.range     = ntc_pkg::RANGE_KEEP;
        end else begin
          cmd_o.load_hi  = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ntc_pkg::AS_NEXT;
        end
      end
      ntc_pkg::S_DIVT: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_interp = 1'b1;
      end
      ntc_pkg::S_WAITT: begin
        cmd_o.load_temp = sts_i.div_done;
        cmd_o.temp_src  = ntc_pkg::TS_INTERP;
      end
      ntc_pkg::S_FIN: cmd_o.publish = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

/* hdl/ntc_table_interpolator.sv */
// ----------------------------------------------------------------------------
// ntc_table_interpolator
// NTC thermistor divider to temperature conversion by table interpolation.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   action, raw_sample, entry_*
//   out      output     out_valid_o / out_ready_i temperature, resistance, status
//   apb      input      psel/penable/pwrite       paddr, pwdata, prdata
//
// A table load beat is written to memory when accepted. A conversion's
// result clamps at the cold or hot end of the table or is interpolated:
// the 40-step shared divider runs once for the ratio and once for the
// offset, and the scan reads one entry per cycle through the single
// memory read port. A zero or over-range sample skips the ratio division.
// Reset returns the controller to idle, clears the result valid flag and
// the previous temperature, and sets the configuration registers to their
// defaults; the table contents are undefined until loaded. A new beat is
// taken while a result waits; a stalled output holds the finished
// conversion in its last state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_table_interpolator #(
  parameter int MAX_POINTS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB-style configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ntc_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Input beats
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [ntc_pkg::RawW-1:0]          raw_sample_i,
  input  logic [4:0]                        entry_index_i,
  input  logic [ntc_pkg::ResW-1:0]          entry_resistance_i,
  input  logic signed [ntc_pkg::TempW-1:0]  entry_temperature_i,
  // Result beats
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ntc_pkg::TempW-1:0]  temperature_o,
  output logic [ntc_pkg::ResW-1:0]          measured_resistance_o,
  output logic [1:0]                        range_status_o
);

  logic [ntc_pkg::ResW-1:0] bottom_q;
  logic [ntc_pkg::RawW-1:0] full_q;
  logic [ntc_pkg::PtsW-1:0] points_q;
  logic                     cfg_we;

  ntc_pkg::cmd_t cmd;
  ntc_pkg::sts_t sts;

  // Registers are written in the access phase; the bus never stalls.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_q <= ntc_pkg::ResW'(10000);
      full_q   <= ntc_pkg::RawW'(4095);
      points_q <= ntc_pkg::PtsW'(2);
    end else if (cfg_we) begin
      case (paddr[3:2])
        ntc_pkg::RegBottom: bottom_q <= pwdata[ntc_pkg::ResW-1:0];
        ntc_pkg::RegFull:   full_q   <= pwdata[ntc_pkg::RawW-1:0];
        ntc_pkg::RegPoints: points_q <= pwdata[ntc_pkg::PtsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ntc_pkg::RegBottom: prdata = {8'b0, bottom_q};
      ntc_pkg::RegFull:   prdata = {16'b0, full_q};
      ntc_pkg::RegPoints: prdata = {26'b0, points_q};
      default:            prdata = '0;
    endcase
  end

  ntc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ntc_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .bottom_i              (bottom_q),
    .full_i                (full_q),
    .points_i              (points_q),
    .raw_sample_i          (raw_sample_i),
    .entry_index_i         (entry_index_i),
    .entry_resistance_i    (entry_resistance_i),
    .entry_temperature_i   (entry_temperature_i),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .temperature_o         (temperature_o),
    .measured_resistance_o (measured_resistance_o),
    .range_status_o        (range_status_o)
  );

endmodule
